[src/mcth_pkg.sv]
package mcth_pkg;

  localparam int COORD_W   = 12;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

  localparam int SCREEN_W_RST = 640;
  localparam int SCREEN_H_RST = 480;

  localparam int HDR_LEFT  = 0;
  localparam int HDR_XSIGN = 4;
  localparam int HDR_YSIGN = 5;

  localparam int CELL_W   = 140;
  localparam int CELL_H   = 90;
  localparam int CELL_GAP = 30;
  localparam int PITCH_X  = CELL_W + CELL_GAP;
  localparam int PITCH_Y  = CELL_H + CELL_GAP;

  // grid offsets are at most 16 bits; reciprocals are exact over that range
  localparam int HOFF_W      = 16;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 24;
  localparam int PROD_W      = HOFF_W + RECIP_W;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_X = 18'd98690;
  localparam logic [RECIP_W-1:0] RECIP_Y = 18'd139811;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] dx_byte;
    logic [7:0] dy_byte;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               moved;
    logic               click;
    logic               hit_valid;
    logic [IDX_W-1:0]   hit_index;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               moved;
    logic               click;
    logic               in_grid;
    logic               w_ge_gap;
    logic [HOFF_W-1:0]  x_off;
    logic [HOFF_W-1:0]  y_off;
    logic [HOFF_W-1:0]  w_off;
  } cur_stage_t;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               moved;
    logic               click;
    logic               in_grid;
    logic               w_ge_gap;
    logic [HOFF_W-1:0]  x_off;
    logic [HOFF_W-1:0]  y_off;
    logic [Q_W-1:0]     col_q;
    logic [Q_W-1:0]     row_q;
    logic [Q_W-1:0]     cols_q;
  } div_stage_t;

endpackage

[src/mouse_cursor_tracker_hit_test_unit.sv]
// PS/2 mouse cursor tracker with icon hit test. Takes one three-byte packet per
// item and returns one result per item: the saturated cursor, a moved flag, the
// left-button press edge and, on a press, the icon cell hit in a 140x90 grid with
// 30 pixel gaps. One item is accepted every cycle unless the output stalls. The rate
// is set by the cursor loop (add and clamp against the stored position), which closes
// combinationally into the position registers; each result then passes the registered
// hit test pipeline: reciprocal multiplies for the cell column, row and column count,
// then remainder checks and the icon index. Screen registers are written through the
// cfg port (index 0 width, 1 height); a write does not move the cursor, the next item
// clamps it.
module mouse_cursor_tracker_hit_test_unit #(
  parameter int ICON_COUNT = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mcth_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mcth_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mcth_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcth_pkg::CFG_W-1:0]     cfg_data
);
  import mcth_pkg::*;

  logic [CFG_W-1:0] scr_w_r, scr_h_r;
  logic             cur_valid, cur_ready;
  cur_stage_t       cur_stage;
  logic             div_valid, div_ready;
  div_stage_t       div_stage;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= CFG_W'(SCREEN_W_RST);
      scr_h_r <= CFG_W'(SCREEN_H_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  scr_w_r <= cfg_data;
        CFG_SCREEN_HEIGHT: scr_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mcth_cursor u_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .ready_o (in_ready),
    .item_i  (in_data),
    .scr_w_i (scr_w_r),
    .scr_h_i (scr_h_r),
    .valid_o (cur_valid),
    .ready_i (cur_ready),
    .stage_o (cur_stage)
  );

  mcth_hit_div u_hit_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (cur_valid),
    .ready_o (cur_ready),
    .stage_i (cur_stage),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .stage_o (div_stage)
  );

  mcth_hit_sel #(
    .ICON_COUNT(ICON_COUNT)
  ) u_hit_sel (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (div_valid),
    .ready_o (div_ready),
    .stage_i (div_stage),
    .valid_o (out_valid),
    .ready_i (out_ready),
    .item_o  (out_data)
  );

endmodule

[src/mcth_cursor.sv]
module mcth_cursor (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  mcth_pkg::in_item_t        item_i,
  input  logic [mcth_pkg::CFG_W-1:0] scr_w_i,
  input  logic [mcth_pkg::CFG_W-1:0] scr_h_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output mcth_pkg::cur_stage_t      stage_o
);
  import mcth_pkg::*;

  localparam int COORD_BITS = COORD_W;
  localparam int SZ_W  = COORD_BITS + 1;
  localparam int SW    = COORD_BITS + 2;
  localparam int EW    = (CFG_W > SZ_W) ? CFG_W : SZ_W;
  localparam logic [EW-1:0] LIM = EW'(2 ** COORD_BITS);
  localparam int RST_W = (SCREEN_W_RST > 2 ** COORD_BITS) ? 2 ** COORD_BITS : SCREEN_W_RST;
  localparam int RST_H = (SCREEN_H_RST > 2 ** COORD_BITS) ? 2 ** COORD_BITS : SCREEN_H_RST;
  localparam logic [COORD_BITS-1:0] RST_X = COORD_BITS'(RST_W / 2);
  localparam logic [COORD_BITS-1:0] RST_Y = COORD_BITS'(RST_H / 2);

  function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    if (e == '0) return SZ_W'(1);
    else if (e > LIM) return SZ_W'(LIM);
    else return SZ_W'(e);
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_axis(input logic signed [SW-1:0] v,
                                                       input logic [SZ_W-1:0] size);
    if (v[SW-1]) return '0;
    else if (v[SW-2:0] >= size) return COORD_BITS'(size - 1'b1);
    else return COORD_BITS'(v[SW-2:0]);
  endfunction

  logic [COORD_BITS-1:0] cur_x_r, cur_y_r;
  logic                  btn_r;
  logic                  valid_r;
  cur_stage_t            stage_r, stage_nxt;

  logic [SZ_W-1:0]       w_eff, h_eff;
  logic signed [SW-1:0]  sx, sy;
  logic [COORD_BITS-1:0] nx, ny;
  logic                  accept;

  assign ready_o = !valid_r || ready_i;
  assign accept  = valid_i && ready_o;
  assign valid_o = valid_r;
  assign stage_o = stage_r;

  always_comb begin
    w_eff = eff_size(scr_w_i);
    h_eff = eff_size(scr_h_i);
    sx = $signed({2'b00, cur_x_r})
       + SW'($signed({item_i.header_byte[HDR_XSIGN], item_i.dx_byte}));
    sy = $signed({2'b00, cur_y_r})
       - SW'($signed({item_i.header_byte[HDR_YSIGN], item_i.dy_byte}));
    nx = clamp_axis(sx, w_eff);
    ny = clamp_axis(sy, h_eff);

    stage_nxt.pos_x    = COORD_W'(nx);
    stage_nxt.pos_y    = COORD_W'(ny);
    stage_nxt.moved    = (nx != cur_x_r) || (ny != cur_y_r);
    stage_nxt.click    = item_i.header_byte[HDR_LEFT] && !btn_r;
    stage_nxt.in_grid  = (HOFF_W'(nx) >= HOFF_W'(CELL_GAP))
                      && (HOFF_W'(ny) >= HOFF_W'(CELL_GAP));
    stage_nxt.x_off    = HOFF_W'(nx) - HOFF_W'(CELL_GAP);
    stage_nxt.y_off    = HOFF_W'(ny) - HOFF_W'(CELL_GAP);
    stage_nxt.w_ge_gap = w_eff >= SZ_W'(CELL_GAP);
    stage_nxt.w_off    = HOFF_W'(w_eff - SZ_W'(CELL_GAP));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= RST_X;
      cur_y_r <= RST_Y;
      btn_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (ready_o) valid_r <= valid_i;
      if (accept) begin
        cur_x_r <= nx;
        cur_y_r <= ny;
        btn_r   <= item_i.header_byte[HDR_LEFT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) stage_r <= stage_nxt;
  end

endmodule

[src/mcth_hit_div.sv]
module mcth_hit_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  mcth_pkg::cur_stage_t stage_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output mcth_pkg::div_stage_t stage_o
);
  import mcth_pkg::*;

  logic       valid_r;
  div_stage_t stage_r, stage_nxt;
  logic [PROD_W-1:0] prod_x, prod_y, prod_c;
  logic       accept;

  assign ready_o = !valid_r || ready_i;
  assign accept  = valid_i && ready_o;
  assign valid_o = valid_r;
  assign stage_o = stage_r;

  always_comb begin
    prod_x = PROD_W'(stage_i.x_off) * PROD_W'(RECIP_X);
    prod_y = PROD_W'(stage_i.y_off) * PROD_W'(RECIP_Y);
    prod_c = PROD_W'(stage_i.w_off) * PROD_W'(RECIP_X);

    stage_nxt.pos_x    = stage_i.pos_x;
    stage_nxt.pos_y    = stage_i.pos_y;
    stage_nxt.moved    = stage_i.moved;
    stage_nxt.click    = stage_i.click;
    stage_nxt.in_grid  = stage_i.in_grid;
    stage_nxt.w_ge_gap = stage_i.w_ge_gap;
    stage_nxt.x_off    = stage_i.x_off;
    stage_nxt.y_off    = stage_i.y_off;
    stage_nxt.col_q    = prod_x[PROD_W-1:RECIP_SHIFT];
    stage_nxt.row_q    = prod_y[PROD_W-1:RECIP_SHIFT];
    stage_nxt.cols_q   = prod_c[PROD_W-1:RECIP_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) stage_r <= stage_nxt;
  end

endmodule

[src/mcth_hit_sel.sv]
module mcth_hit_sel #(
  parameter int ICON_COUNT = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  mcth_pkg::div_stage_t stage_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output mcth_pkg::out_item_t  item_o
);
  import mcth_pkg::*;

  localparam int IW = $clog2(ICON_COUNT + 1);
  localparam int PW = 2 * IW;

  logic            valid_r;
  out_item_t       item_r, item_nxt;
  logic [HOFF_W-1:0] rem_x, rem_y;
  logic [Q_W-1:0]  cols_full;
  logic [IW-1:0]   cols_n;
  logic [PW-1:0]   idx;
  logic            col_ok, lim_ok, hit;
  logic            accept;

  assign ready_o = !valid_r || ready_i;
  assign accept  = valid_i && ready_o;
  assign valid_o = valid_r;
  assign item_o  = item_r;

  always_comb begin
    rem_x = stage_i.x_off - (HOFF_W'(stage_i.col_q) * HOFF_W'(PITCH_X));
    rem_y = stage_i.y_off - (HOFF_W'(stage_i.row_q) * HOFF_W'(PITCH_Y));
    cols_full = (!stage_i.w_ge_gap || stage_i.cols_q == '0) ? Q_W'(1) : stage_i.cols_q;
    col_ok = stage_i.col_q < cols_full;
    lim_ok = (stage_i.col_q < Q_W'(ICON_COUNT)) && (stage_i.row_q < Q_W'(ICON_COUNT));
    cols_n = (cols_full < Q_W'(ICON_COUNT)) ? IW'(cols_full) : IW'(ICON_COUNT);
    idx = PW'(IW'(stage_i.row_q)) * PW'(cols_n) + PW'(IW'(stage_i.col_q));
    hit = stage_i.click && stage_i.in_grid
       && (rem_x < HOFF_W'(CELL_W)) && (rem_y < HOFF_W'(CELL_H))
       && col_ok && lim_ok && (idx < PW'(ICON_COUNT));

    item_nxt.pos_x     = stage_i.pos_x;
    item_nxt.pos_y     = stage_i.pos_y;
    item_nxt.moved     = stage_i.moved;
    item_nxt.click     = stage_i.click;
    item_nxt.hit_valid = hit;
    item_nxt.hit_index = hit ? IDX_W'(idx) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= item_nxt;
  end

endmodule

[src/mcth_checker.sv]
module mcth_checker #(
  parameter int ICON_COUNT = 7
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input mcth_pkg::out_item_t out_data
);
  import mcth_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  a_hit_needs_click: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit_valid |-> out_data.click)
    else $error("hit without click");

  a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit_valid |-> out_data.hit_index == '0)
    else $error("nonzero index without hit");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit_valid |->
      (ICON_COUNT > 7) || (out_data.hit_index < IDX_W'(ICON_COUNT)))
    else $error("hit index beyond icon count");

endmodule

bind mouse_cursor_tracker_hit_test_unit mcth_checker #(
  .ICON_COUNT(ICON_COUNT)
) u_mcth_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/sv/cursor_result_checker.sv]
`timescale 1ns / 1ps

module cursor_result_checker
  import mcth_pkg::*;
#(
  parameter int ICON_COUNT = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   reports_waiting
);

  logic [CFG_W-1:0]   screen_w;
  logic [CFG_W-1:0]   screen_h;
  logic [COORD_W-1:0] cursor_x;
  logic [COORD_W-1:0] cursor_y;
  logic               left_prev;
  out_item_t          expected_reports[$];
  int                 mismatches = 0;

  assign fail_count = mismatches;

  function automatic int screen_span(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > (1 << COORD_W)) return 1 << COORD_W;
    return v;
  endfunction

  function automatic out_item_t predict_cursor_update(in_item_t pkt);
    int        w, h, dx, dy, nx, ny, cols, ox, oy, col, row, icon;
    logic      left, press;
    out_item_t rpt;
    w = screen_span(screen_w);
    h = screen_span(screen_h);
    left = pkt.header_byte[HDR_LEFT];
    dx = pkt.dx_byte;
    if (pkt.header_byte[HDR_XSIGN]) dx -= 256;
    dy = pkt.dy_byte;
    if (pkt.header_byte[HDR_YSIGN]) dy -= 256;
    nx = int'(cursor_x) + dx;
    ny = int'(cursor_y) - dy;
    if (nx < 0) nx = 0;
    else if (nx >= w) nx = w - 1;
    if (ny < 0) ny = 0;
    else if (ny >= h) ny = h - 1;
    press = left && !left_prev;
    cols = (w >= CELL_GAP) ? (w - CELL_GAP) / PITCH_X : 0;
    if (cols < 1) cols = 1;
    rpt = '0;
    rpt.pos_x = COORD_W'(nx);
    rpt.pos_y = COORD_W'(ny);
    rpt.moved = (nx != int'(cursor_x)) || (ny != int'(cursor_y));
    rpt.click = press;
    if (press && nx >= CELL_GAP && ny >= CELL_GAP) begin
      ox = nx - CELL_GAP;
      oy = ny - CELL_GAP;
      col = ox / PITCH_X;
      row = oy / PITCH_Y;
      icon = row * cols + col;
      if (ox % PITCH_X < CELL_W && oy % PITCH_Y < CELL_H && col < cols && icon < ICON_COUNT)
      begin
        rpt.hit_valid = 1'b1;
        rpt.hit_index = IDX_W'(icon);
      end
    end
    cursor_x = COORD_W'(nx);
    cursor_y = COORD_W'(ny);
    left_prev = left;
    return rpt;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      screen_w = CFG_W'(SCREEN_W_RST);
      screen_h = CFG_W'(SCREEN_H_RST);
      cursor_x = COORD_W'(screen_span(screen_w) / 2);
      cursor_y = COORD_W'(screen_span(screen_h) / 2);
      left_prev = 1'b0;
      expected_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("result with nothing expected: pos_x %0d pos_y %0d",
                 out_data.pos_x, out_data.pos_y);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("pos_x", want.pos_x, out_data.pos_x);
          check_field("pos_y", want.pos_y, out_data.pos_y);
          check_field("moved", want.moved, out_data.moved);
          check_field("click", want.click, out_data.click);
          check_field("hit_valid", want.hit_valid, out_data.hit_valid);
          check_field("hit_index", want.hit_index, out_data.hit_index);
        end
      end
      if (in_valid && in_ready) expected_reports.push_back(predict_cursor_update(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCREEN_WIDTH:  screen_w = cfg_data;
          CFG_SCREEN_HEIGHT: screen_h = cfg_data;
          default: ;
        endcase
      end
    end
    reports_waiting <= expected_reports.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import mcth_pkg::*;

  localparam int ICONS          = 7;
  localparam int PHASES         = 12;
  localparam int PHASE_PACKETS  = 146;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SCREEN_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;

  int fail_count;
  int reports_waiting;
  int packets_sent = 0;
  int home_steps = 3;
  int quiet_cycles = 0;
  bit gaps_on = 1'b0;
  bit hold_now = 1'b0;
  int col_offs[6] = '{-1, 0, 70, 139, 140, 169};
  int row_offs[6] = '{-1, 0, 45, 89, 90, 119};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  mouse_cursor_tracker_hit_test_unit #(
    .ICON_COUNT(ICONS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  cursor_result_checker #(
    .ICON_COUNT(ICONS)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .reports_waiting(reports_waiting)
  );

  always begin
    @(posedge clk);
    if (hold_now) begin
      hold_now = 1'b0;
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_ready <= 1'b1;
    end else if (rst_n && gaps_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx, input logic [7:0] dy);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{header_byte: hdr, dx_byte: dx, dy_byte: dy};
    do @(posedge clk); while (!in_ready);
    packets_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_screen(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    int span;
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    span = (w > h) ? w : h;
    if (span > (1 << COORD_W)) span = 1 << COORD_W;
    home_steps = span / 255 + 1;
  endtask

  task automatic go_home();
    repeat (home_steps) send_packet(8'(1 << HDR_XSIGN), 8'h00, 8'hFF);
  endtask

  task automatic aim_and_click(input int tx, input int ty);
    int         sx, sy;
    logic [7:0] hdr;
    go_home();
    while (tx > 0 || ty > 0) begin
      sx = (tx > 255) ? 255 : tx;
      sy = (ty > 256) ? 256 : ty;
      hdr = (sy > 0) ? 8'(1 << HDR_YSIGN) : 8'h00;
      send_packet(hdr, 8'(sx), 8'(256 - sy));
      tx -= sx;
      ty -= sy;
    end
    send_packet(8'(1 << HDR_LEFT), 8'h00, 8'h00);
  endtask

  initial begin
    int         phase_end, tx, ty;
    logic [8:0] mvx, mvy;
    logic [7:0] hdr;
    logic [12:0] w, h;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_packet(8'h00, 8'h00, 8'h00);
    send_packet(8'(1 << HDR_XSIGN), 8'h00, 8'h00);
    send_packet(8'(1 << HDR_YSIGN), 8'h00, 8'h00);
    send_packet(8'h00, 8'hFF, 8'hFF);
    go_home();
    send_packet(8'h21, 8'd30, 8'd226);
    send_packet(8'h01, 8'h00, 8'h00);
    send_packet(8'(1 << HDR_XSIGN), 8'hFF, 8'h00);
    send_packet(8'h01, 8'h00, 8'h00);
    send_packet(8'(1 << HDR_YSIGN), 8'd171, 8'd136);
    send_packet(8'h01, 8'h00, 8'h00);
    aim_and_click(100, 300);
    aim_and_click(200, 300);
    send_packet(8'h00, 8'h00, 8'h00);
    write_screen(13'd0, 13'd0);
    send_packet(8'h01, 8'h00, 8'h00);
    write_screen(13'd29, 13'd8191);
    send_packet(8'h00, 8'h00, 8'h00);
    send_packet(8'hFF, 8'hFF, 8'h00);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin w = 13'd4096; h = 13'd4096; end
        1: begin w = 13'd8191; h = 13'd1; end
        2: begin w = 13'd1; h = 13'd8191; end
        3: begin w = 13'd30; h = 13'd29; end
        PHASES - 1: begin w = 13'd1024; h = 13'd768; end
        default: begin
          if ($urandom_range(0, 2) == 0) begin
            w = 13'($urandom_range(0, 8191));
            h = 13'($urandom_range(0, 8191));
          end else begin
            w = 13'($urandom_range(170, 1200));
            h = 13'($urandom_range(120, 900));
          end
        end
      endcase
      write_screen(w, h);
      if (phase == 0) hold_now = 1'b1;
      phase_end = packets_sent + PHASE_PACKETS;
      while (packets_sent < phase_end) begin
        gaps_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            send_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
          end
          3, 4, 5: begin
            mvx = 9'($urandom_range(0, 16) - 8);
            mvy = 9'($urandom_range(0, 16) - 8);
            hdr = 8'($urandom_range(0, 1));
            hdr[HDR_XSIGN] = mvx[8];
            hdr[HDR_YSIGN] = mvy[8];
            send_packet(hdr, mvx[7:0], mvy[7:0]);
          end
          6, 7, 8: begin
            if ($urandom_range(0, 3) == 0) begin
              tx = $urandom_range(0, 1000);
              ty = $urandom_range(0, 700);
            end else begin
              tx = 30 + 170 * $urandom_range(0, 3) + col_offs[$urandom_range(0, 5)];
              ty = 30 + 120 * $urandom_range(0, 3) + row_offs[$urandom_range(0, 5)];
            end
            aim_and_click(tx, ty);
            if ($urandom_range(0, 1) == 0) send_packet(8'h00, 8'h00, 8'h00);
          end
          default: go_home();
        endcase
      end
    end

    gaps_on = 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
